### rtl/core/swap_slot_allocator_defines.svh
// assertion macros used by the swap slot allocator sequencer
`ifndef SWAP_SLOT_ALLOCATOR_DEFINES_SVH
`define SWAP_SLOT_ALLOCATOR_DEFINES_SVH

// property checked on every rising edge of clk_i outside reset
`define SSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define SSA_ASSERT_NEVER(label, cond, msg) \
  `SSA_ASSERT(label, !(cond), msg)

`endif

### rtl/core/ssa_pkg.sv
// types and constants of the swap slot allocator
package ssa_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned OWNER_W  = 16;
  localparam int unsigned PAGE_W   = 20;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned SECTOR_W = 13;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE_PAGE  = 2'd1,
    OP_FREE_OWNER = 2'd2
  } ssa_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } ssa_state_e;

  typedef struct packed {
    logic               used;
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  page;
  } ssa_entry_t;

  typedef struct packed {
    logic       shift;
    ssa_entry_t tail;
  } ssa_ring_ctl_t;

endpackage

### rtl/core/ssa_in_if.sv
// request channel: operation, owner and page
interface ssa_in_if
  import ssa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [OWNER_W-1:0] owner_id;
  logic [PAGE_W-1:0]  page_number;

  modport source (output valid, operation, owner_id, page_number, input ready);
  modport sink   (input valid, operation, owner_id, page_number, output ready);
endinterface

### rtl/core/ssa_out_if.sv
// result channel: status, slot, first sector and freed count
interface ssa_out_if
  import ssa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                status;
  logic [SLOT_W-1:0]   slot_index;
  logic [SECTOR_W-1:0] first_sector;
  logic [COUNT_W-1:0]  freed_count;

  modport source (output valid, status, slot_index, first_sector, freed_count, input ready);
  modport sink   (input valid, status, slot_index, first_sector, freed_count, output ready);
endinterface

### rtl/core/swap_slot_allocator.sv
// swap slot allocator top level: slot ring, sequencer and slot count register
//
//  channel   dir  handshake        payload
//  in_i      in   valid / ready    operation, owner_id, page_number
//  out_o     out  valid / ready    status, slot_index, first_sector, freed_count
//  cfg       in   cfg_we_i only    cfg_data_i -> slot_count
//
// for each word the whole slot ring rotates once past the
// single compare and update point at its head, one slot per cycle.
// after reset a clearing pass frees every slot; no word is taken until it ends.
// a result waits in the output register while the next word is taken; a scan that
// finishes while that register is still full holds until the result is taken.
module swap_slot_allocator
  import ssa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS        = 1024,
  parameter int unsigned SECTORS_PER_SLOT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_data_i,
  ssa_in_if.sink             in_i,
  ssa_out_if.source          out_o
);

  logic [COUNT_W-1:0] slot_count_q;
  ssa_ring_ctl_t      ring;
  ssa_entry_t         cell_q [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RESET;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_data_i;
    end
  end

  // ring: each cell takes its upper neighbour, the top cell takes the updated head
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    ssa_entry_t cell_d;
    if (k == NUM_SLOTS - 1) begin : g_top
      assign cell_d = ring.tail;
    end else begin : g_mid
      assign cell_d = cell_q[k+1];
    end
    ssa_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ring.shift),
      .d_i     (cell_d),
      .q_o     (cell_q[k])
    );
  end

  ssa_ctrl #(
    .NUM_SLOTS        (NUM_SLOTS),
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_count_i (slot_count_q),
    .head_i       (cell_q[0]),
    .ring_o       (ring),
    .in_i         (in_i),
    .out_o        (out_o)
  );

endmodule

### rtl/core/ssa_cell.sv
// one slot entry of the rotating ring
module ssa_cell
  import ssa_pkg::*;
(
  input  logic       clk_i,
  input  logic       shift_i,
  input  ssa_entry_t d_i,
  output ssa_entry_t q_o
);

  ssa_entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

### rtl/core/ssa_ctrl.sv
// sequencer and head-of-ring update logic of the swap slot allocator
`include "swap_slot_allocator_defines.svh"

module ssa_ctrl
  import ssa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS        = 1024,
  parameter int unsigned SECTORS_PER_SLOT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] slot_count_i,
  input  ssa_entry_t         head_i,
  output ssa_ring_ctl_t      ring_o,
  ssa_in_if.sink             in_i,
  ssa_out_if.source          out_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned SPS_W = $clog2(SECTORS_PER_SLOT + 1);
  localparam int unsigned PRD_W = IDX_W + SPS_W;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_SLOTS - 1);

  ssa_state_e          state_q, state_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic [OP_W-1:0]     op_q;
  logic [OWNER_W-1:0]  owner_q;
  logic [PAGE_W-1:0]   page_q;
  logic                found_q;
  logic [IDX_W-1:0]    first_q;
  logic [CNT_W-1:0]    count_q;

  logic                out_valid_q;
  logic                status_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SECTOR_W-1:0] sector_q;
  logic [COUNT_W-1:0]  freed_q;

  logic                accept;
  logic                take;
  logic                emit;
  logic                owner_hit;
  logic                in_range;
  logic                fail;
  logic [PRD_W-1:0]    sector_full;

  assign accept    = in_i.valid && in_i.ready;
  assign owner_hit = head_i.used && (head_i.owner == owner_q);
  // allocate only looks below the configured slot count
  assign in_range  = CMP_W'(step_q) < CMP_W'(slot_count_i);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ring_o      = '{shift: 1'b0, tail: head_i};
    take        = 1'b0;
    emit        = 1'b0;
    in_i.ready  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ring_o.shift     = 1'b1;
        ring_o.tail.used = 1'b0;
        step_d           = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ring_o.shift = 1'b1;
        unique case (op_q)
          OP_ALLOC: begin
            if (!found_q && in_range && !head_i.used) begin
              ring_o.tail = '{used: 1'b1, owner: owner_q, page: page_q};
              take        = 1'b1;
            end
          end
          OP_FREE_PAGE: begin
            if (!found_q && owner_hit && (head_i.page == page_q)) begin
              ring_o.tail.used = 1'b0;
              take             = 1'b1;
            end
          end
          OP_FREE_OWNER: begin
            if (owner_hit) begin
              ring_o.tail.used = 1'b0;
              take             = 1'b1;
            end
          end
          default: begin
          end
        endcase
        step_d = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // word under scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      count_q <= '0;
    end else if (accept) begin
      found_q <= 1'b0;
      count_q <= '0;
    end else if (take) begin
      found_q <= 1'b1;
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.operation;
      owner_q <= in_i.owner_id;
      page_q  <= in_i.page_number;
    end
    if (take && !found_q) begin
      first_q <= step_q[IDX_W-1:0];
    end
  end

  assign fail        = !found_q;
  assign sector_full = PRD_W'(first_q) * PRD_W'(SECTORS_PER_SLOT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= fail;
      slot_q   <= fail ? '0 : SLOT_W'(first_q);
      sector_q <= fail ? '0 : SECTOR_W'(sector_full);
      freed_q  <= (fail || (op_q == OP_ALLOC)) ? '0 : COUNT_W'(count_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.slot_index   = slot_q;
  assign out_o.first_sector = sector_q;
  assign out_o.freed_count  = freed_q;

  `SSA_ASSERT(a_accept_starts_scan, accept |=> (state_q == ST_SCAN) && (step_q == '0),
    "accepted word did not start a scan at slot zero")
  `SSA_ASSERT(a_found_has_count, found_q |-> (count_q != '0),
    "match recorded without a count")
  `SSA_ASSERT_NEVER(a_step_range, step_q > LAST_STEP,
    "scan step beyond the last slot")
  `SSA_ASSERT(a_emit_loads_output, emit |=> out_o.valid && (state_q == ST_IDLE),
    "finished scan did not present its result")

endmodule
